// ===== rtl/rec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rec_pkg: shared definitions for the raster enclosure check
// Grid limits, field widths, register indexes and the cell classifier.
// ----------------------------------------------------------------------------
package rec_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // Line buffer words: bank bit plus the column without its parity bit.
  localparam int LB_AW    = COL_W;
  localparam int LB_DEPTH = 2 ** LB_AW;

  // Configuration register widths and indexes.
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = 1 + ROW_W + COL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Cell characters.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;

  typedef struct packed {
    logic is_allowed;
    logic is_open;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] ch);
    cls_t res;
    res.is_open    = (ch == CH_ZERO) || (ch == CH_TWO);
    res.is_allowed = (ch == CH_ZERO) || (ch == CH_ONE) || (ch == CH_TWO);
    return res;
  endfunction

endpackage

// ===== rtl/raster_enclosure_check_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_enclosure_check_3x3: 3x3 neighborhood closure check on a raster grid
// Flags the first open cell that touches a disallowed cell in its window.
// ----------------------------------------------------------------------------
// Usage:
//   Program grid_width (index 0) and grid_height (index 1) on the cfg channel
//   while the block is idle; a size of 0 acts as 1, larger sizes saturate.
//   Stream the grid in raster order on s_axis, one cell byte per item.
//   After the last cell one item appears on m_axis with the closed flag and
//   the row and column of the first failing open cell (both 0 if closed).
// Timing:
//   One cell per cycle sustained while s_axis_tready stays high. The last
//   cell is registered together with its line buffer read, and the window
//   check and the running minimum then load the result register.
//   The line buffers are two parity-split memories (even and odd columns),
//   each with a row bank bit, so the three upper taps are read in one access;
//   the left tap comes from the previous cell, or from a line buffer when the column was pulled back.
// Reset and stalls:
//   Reset clears the counters, failure state and the stream registers and
//   sets the size registers to 256 x 1024; line buffers are not cleared.
//   A result waiting on m_axis does not block input; only when a second
//   grid ends while it is still waiting does s_axis_tready drop.
// ----------------------------------------------------------------------------
module raster_enclosure_check_3x3 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rec_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rec_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Cell stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rec_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] cell_char
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] grid_closed, [10:1] fail_row, [18:11] fail_col, rest zero
  output logic [rec_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int COL_W = rec_pkg::COL_W;
  localparam int ROW_W = rec_pkg::ROW_W;
  localparam int WW    = rec_pkg::CFG_WIDTH_W;
  localparam int HW    = rec_pkg::CFG_HEIGHT_W;
  localparam int AW    = rec_pkg::LB_AW;

  typedef struct packed {
    logic                last;
    logic                clamp;
    logic                par;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    rec_pkg::cls_t       cls;
    rec_pkg::cls_t       left;
    logic                has_up;
    logic                has_lf;
    logic                has_ur;
  } s1_t;

  // Configuration registers.
  logic [WW-1:0] cfg_width_q;
  logic [HW-1:0] cfg_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WW'(rec_pkg::MAX_COLS);
      cfg_height_q <= HW'(rec_pkg::MAX_ROWS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rec_pkg::CFG_GRID_WIDTH:  cfg_width_q  <= cfg_data_i[WW-1:0];
        rec_pkg::CFG_GRID_HEIGHT: cfg_height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: position, classification, line buffer access.
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             mid_bank_q;
  rec_pkg::cls_t    prev_cls_q;

  logic             acc;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic             col_clamp;
  logic             row_clamp;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c_m1;
  logic [COL_W-1:0] c_p1;
  logic             last_col;
  logic             last_row;
  rec_pkg::cls_t    cur_cls;
  logic             upper_bank;

  logic [1:0][AW-1:0] addr_a;
  logic [1:0][AW-1:0] addr_b;
  logic [1:0]         wr_en;
  logic [AW-1:0]      wr_addr;
  rec_pkg::cls_t      rd_a [2];
  rec_pkg::cls_t      rd_b [2];

  logic s1_valid_q;
  s1_t  s1_q;
  logic s1_hold;
  logic s1_adv;

  assign s1_hold       = s1_valid_q && s1_q.last && m_axis_tvalid && !m_axis_tready;
  assign s1_adv        = s1_valid_q && !s1_hold;
  assign s_axis_tready = !s1_hold;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (cfg_width_q > WW'(rec_pkg::MAX_COLS)) begin
      w_eff = WW'(rec_pkg::MAX_COLS);
    end else begin
      w_eff = cfg_width_q;
    end
    if (cfg_height_q == '0) begin
      h_eff = HW'(1);
    end else if (cfg_height_q > HW'(rec_pkg::MAX_ROWS)) begin
      h_eff = HW'(rec_pkg::MAX_ROWS);
    end else begin
      h_eff = cfg_height_q;
    end

    col_clamp = WW'(col_q) >= w_eff;
    row_clamp = HW'(row_q) >= h_eff;
    c         = col_clamp ? COL_W'(w_eff - WW'(1)) : col_q;
    r         = row_clamp ? ROW_W'(h_eff - HW'(1)) : row_q;
    c_m1      = c - COL_W'(1);
    c_p1      = c + COL_W'(1);
    last_col  = (WW'(c) + WW'(1)) >= w_eff;
    last_row  = (HW'(r) + HW'(1)) >= h_eff;
    cur_cls   = rec_pkg::classify(s_axis_tdata);

    upper_bank = ~mid_bank_q;
    wr_addr    = {mid_bank_q, c[COL_W-1:1]};
    // The memory of the cell's own parity gives the tap straight above; the
    // other one gives the upper-left tap and either the upper-right tap or,
    // when the column was pulled back to the row end, the left tap.
    for (int p = 0; p < 2; p++) begin
      if (c[0] == 1'(p)) begin
        addr_a[p] = {upper_bank, c[COL_W-1:1]};
        wr_en[p]  = acc;
      end else begin
        addr_a[p] = {upper_bank, c_m1[COL_W-1:1]};
        wr_en[p]  = 1'b0;
      end
      addr_b[p] = col_clamp ? {mid_bank_q, c_m1[COL_W-1:1]}
                            : {upper_bank, c_p1[COL_W-1:1]};
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_lb
    rec_pkg::cls_t lb_mem [rec_pkg::LB_DEPTH];
    rec_pkg::cls_t rd_a_q;
    rec_pkg::cls_t rd_b_q;

    always_ff @(posedge clk_i) begin
      if (wr_en[p]) begin
        lb_mem[wr_addr] <= cur_cls;
      end
      if (acc) begin
        rd_a_q <= lb_mem[addr_a[p]];
        rd_b_q <= lb_mem[addr_b[p]];
      end
    end

    assign rd_a[p] = rd_a_q;
    assign rd_b[p] = rd_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      mid_bank_q <= 1'b0;
    end else if (acc) begin
      if (last_col && last_row) begin
        col_q <= '0;
        row_q <= '0;
      end else if (last_col) begin
        col_q      <= '0;
        row_q      <= r + ROW_W'(1);
        mid_bank_q <= ~mid_bank_q;
      end else begin
        col_q <= c_p1;
        row_q <= r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_cls_q  <= cur_cls;
      s1_q.last   <= last_col && last_row;
      s1_q.clamp  <= col_clamp;
      s1_q.par    <= c[0];
      s1_q.row    <= r;
      s1_q.col    <= c;
      s1_q.cls    <= cur_cls;
      s1_q.left   <= prev_cls_q;
      s1_q.has_up <= (r != '0);
      s1_q.has_lf <= (c != '0);
      s1_q.has_ur <= (r != '0) && !last_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (!s1_hold) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1: window check and running minimum of failing positions.
  rec_pkg::cls_t    up_c;
  rec_pkg::cls_t    ul_c;
  rec_pkg::cls_t    ur_c;
  rec_pkg::cls_t    lf_c;
  logic             has_ul;
  logic             ul_fail;
  logic             up_fail;
  logic             ur_fail;
  logic             lf_fail;
  logic             self_fail;
  logic             cand_any;
  logic [ROW_W-1:0] cand_row;
  logic [COL_W-1:0] cand_col;
  logic             take;
  logic             fin_seen;
  logic [ROW_W-1:0] fin_row;
  logic [COL_W-1:0] fin_col;

  logic             fail_seen_q;
  logic [ROW_W-1:0] ff_row_q;
  logic [COL_W-1:0] ff_col_q;

  always_comb begin
    up_c   = rd_a[s1_q.par];
    ul_c   = rd_a[~s1_q.par];
    ur_c   = rd_b[~s1_q.par];
    lf_c   = s1_q.clamp ? rd_b[~s1_q.par] : s1_q.left;
    has_ul = s1_q.has_up && s1_q.has_lf;

    // A neighbor fails when the current cell is not allowed and it is open.
    ul_fail = has_ul      && !s1_q.cls.is_allowed && ul_c.is_open;
    up_fail = s1_q.has_up && !s1_q.cls.is_allowed && up_c.is_open;
    ur_fail = s1_q.has_ur && !s1_q.cls.is_allowed && ur_c.is_open;
    lf_fail = s1_q.has_lf && !s1_q.cls.is_allowed && lf_c.is_open;
    self_fail = s1_q.cls.is_open &&
                ((has_ul      && !ul_c.is_allowed) ||
                 (s1_q.has_up && !up_c.is_allowed) ||
                 (s1_q.has_ur && !ur_c.is_allowed) ||
                 (s1_q.has_lf && !lf_c.is_allowed));

    // Candidates in raster order: upper row first, then left, then self.
    cand_any = ul_fail || up_fail || ur_fail || lf_fail || self_fail;
    cand_row = s1_q.row;
    cand_col = s1_q.col;
    if (ul_fail) begin
      cand_row = s1_q.row - ROW_W'(1);
      cand_col = s1_q.col - COL_W'(1);
    end else if (up_fail) begin
      cand_row = s1_q.row - ROW_W'(1);
    end else if (ur_fail) begin
      cand_row = s1_q.row - ROW_W'(1);
      cand_col = s1_q.col + COL_W'(1);
    end else if (lf_fail) begin
      cand_col = s1_q.col - COL_W'(1);
    end

    take     = cand_any && (!fail_seen_q || ({cand_row, cand_col} < {ff_row_q, ff_col_q}));
    fin_seen = fail_seen_q || cand_any;
    fin_row  = take ? cand_row : ff_row_q;
    fin_col  = take ? cand_col : ff_col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_seen_q <= 1'b0;
    end else if (s1_adv) begin
      fail_seen_q <= s1_q.last ? 1'b0 : fin_seen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ff_row_q <= fin_row;
      ff_col_q <= fin_col;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_q.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last) begin
      m_axis_tdata <= rec_pkg::OUT_DATA_W'({
                        (fin_seen ? fin_col : COL_W'(0)),
                        (fin_seen ? fin_row : ROW_W'(0)),
                        !fin_seen});
    end
  end

  // Checks.
  a_hold_keeps_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_hold |=> s1_valid_q && $stable(s1_q.row) && $stable(s1_q.col))
    else $error("stalled cell in the check stage changed");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.last |=> m_axis_tvalid)
    else $error("last cell of a grid produced no result");

  a_closed_has_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[ROW_W+COL_W:1] == '0)
    else $error("closed grid reports a failing position");

  a_bank_swaps_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_bank_q != $past(mid_bank_q) |-> $past(acc && last_col && !last_row))
    else $error("line buffer bank swapped away from a row end");

endmodule
